[design/header_signature_window_matcher_core_macros.svh]
// assertion macros for the header signature matcher core
`ifndef HEADER_SIGNATURE_WINDOW_MATCHER_CORE_MACROS_SVH
`define HEADER_SIGNATURE_WINDOW_MATCHER_CORE_MACROS_SVH

// check on every clock edge outside reset
`define HSWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check on every clock edge, reset included
`define HSWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

[design/hswm_pkg.sv]
// package with constants, types and the signature table of the header matcher
`timescale 1ns / 1ps

package hswm_pkg;

  // number of header bytes that are examined
  localparam int unsigned HEADER_BYTES = 1024;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES + 1);
  localparam int unsigned HIST_LEN     = 11;
  localparam int unsigned SIG_COUNT    = 11;

  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [HIST_LEN-1:0][7:0]   hist_t;
  typedef logic [SIG_COUNT-1:0]       sig_flags_t;

  // signature indexes, in table order
  localparam int unsigned S_LUKS = 0;
  localparam int unsigned S_FVE  = 1;
  localparam int unsigned S_ENCR = 2;
  localparam int unsigned S_PROT = 3;
  localparam int unsigned S_SB1  = 4;
  localparam int unsigned S_SB2  = 5;
  localparam int unsigned S_PCGM = 6;
  localparam int unsigned S_SGM  = 7;
  localparam int unsigned S_SGE  = 8;
  localparam int unsigned S_WMSD = 9;
  localparam int unsigned S_PGP  = 10;

  // result codes
  typedef enum logic [3:0] {
    CODE_NONE    = 4'd0,
    CODE_FVE     = 4'd1,
    CODE_LUKS    = 4'd2,
    CODE_ENCR    = 4'd3,
    CODE_PGP     = 4'd4,
    CODE_SB      = 4'd5,
    CODE_SGX     = 4'd6,
    CODE_PCGM    = 4'd7,
    CODE_PROT    = 4'd8,
    CODE_WMSD    = 4'd9
  } found_code_e;

  // check set selection
  localparam logic CHECK_VOLUME = 1'b0;
  localparam logic CHECK_DISK   = 1'b1;

  // signature lengths and allowed start offsets
  localparam int unsigned SIG_LEN [SIG_COUNT] = '{6, 8, 7, 7, 8, 8, 4, 6, 6, 4, 11};
  localparam int unsigned SIG_LO  [SIG_COUNT] = '{0, 0, 0, 80, 0, 0, 0, 110, 110, 236, 0};
  localparam int unsigned SIG_HI  [SIG_COUNT] = '{0, 16, 0, 100, 32, 32, 32, 150, 150, 256, 32};

  // signature bytes, first byte at index 0, unused tail zero
  localparam logic [7:0] SIG_BYTES [SIG_COUNT][HIST_LEN] = '{
    '{8'h4C, 8'h55, 8'h4B, 8'h53, 8'hBA, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h46, 8'h56, 8'h45, 8'h2D, 8'h46, 8'h53, 8'h2D, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6E, 8'h63, 8'h72, 8'h64, 8'h73, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h72, 8'h6F, 8'h74, 8'h65, 8'h63, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h61, 8'h66, 8'h65, 8'h62, 8'h6F, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h61, 8'h66, 8'h65, 8'h42, 8'h6F, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h43, 8'h47, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h47, 8'h4D, 8'h34, 8'h30, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h47, 8'h45, 8'h34, 8'h30, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h4D, 8'h53, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hEB, 8'h48, 8'h90, 8'h50, 8'h47, 8'h50, 8'h47, 8'h55, 8'h41, 8'h52, 8'h44}
  };

endpackage

[design/header_signature_window_matcher_core.sv]
// top level of the header signature window matcher
//
// Usage: header bytes of an image stream in on the slave channel, one byte
// per transaction in tdata, with tlast on the final byte of the header run.
// A new byte may follow every cycle while s_axis_tready is high.
// The byte history, byte counter and sticky match flags update in the cycle
// the byte is accepted, set by one compare stage over the eleven signatures.
// On a tlast transaction one result transaction waits on the master channel
// from the next cycle: the found code and the short flag. A result register
// sits between the two sides; a new byte is accepted while the result is
// empty or being taken in the same cycle, so a stalled receiver holds the
// slave side as soon as a result waits in the register.
// Bytes past the header length are accepted and dropped.
// The cfg channel writes the check set select (0 volume, 1 disk); it is
// always ready. The user must write it only while the block is idle;
// the block does not check this. Reset clears history, counter, flags, the
// check set and result valid bit; after each tlast stream state is reset.
`timescale 1ns / 1ps
`include "header_signature_window_matcher_core_macros.svh"

module header_signature_window_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,        // check_set
  // byte input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,      // [7:0] data_byte
  input  logic       s_axis_tlast,      // last
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata       // [3:0] found_code, [4] header_short, [7:5] zero
);

  logic                   check_set_q;
  hswm_pkg::hist_t        hist_q, hist_d;
  hswm_pkg::pos_t         pos_q, pos_d, pos_upd;
  hswm_pkg::sig_flags_t   flags_q, flags_d, flags_upd, hit;
  logic                   out_valid_q, out_valid_d;
  hswm_pkg::found_code_e  out_code_q, out_code_d, code_sel;
  logic                   out_short_q, out_short_d;
  logic                   s_acc;
  logic                   active;
  hswm_pkg::hist_t        hist_new;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // history with the incoming byte shifted in
  assign active   = (pos_q < hswm_pkg::pos_t'(hswm_pkg::HEADER_BYTES));
  assign hist_new = {hist_q[hswm_pkg::HIST_LEN-2:0], s_axis_tdata};

  hswm_sig_match u_match (
    .hist_i   (hist_new),
    .pos_i    (pos_q),
    .active_i (active),
    .hit_o    (hit)
  );

  // stream state after this byte, before end of run clearing
  assign pos_upd   = active ? pos_q + hswm_pkg::pos_t'(1) : pos_q;
  assign flags_upd = flags_q | hit;

  // priority pick over the updated flags
  always_comb begin
    code_sel = hswm_pkg::CODE_NONE;
    if (check_set_q == hswm_pkg::CHECK_VOLUME) begin
      if (flags_upd[hswm_pkg::S_FVE])       code_sel = hswm_pkg::CODE_FVE;
      else if (flags_upd[hswm_pkg::S_LUKS]) code_sel = hswm_pkg::CODE_LUKS;
      else if (flags_upd[hswm_pkg::S_ENCR]) code_sel = hswm_pkg::CODE_ENCR;
    end else begin
      if (flags_upd[hswm_pkg::S_PGP]) begin
        code_sel = hswm_pkg::CODE_PGP;
      end else if (flags_upd[hswm_pkg::S_SB1] || flags_upd[hswm_pkg::S_SB2]) begin
        code_sel = hswm_pkg::CODE_SB;
      end else if (flags_upd[hswm_pkg::S_SGM] || flags_upd[hswm_pkg::S_SGE]) begin
        code_sel = hswm_pkg::CODE_SGX;
      end else if (flags_upd[hswm_pkg::S_PCGM]) begin
        code_sel = hswm_pkg::CODE_PCGM;
      end else if (flags_upd[hswm_pkg::S_PROT]) begin
        code_sel = hswm_pkg::CODE_PROT;
      end else if (flags_upd[hswm_pkg::S_WMSD]) begin
        code_sel = hswm_pkg::CODE_WMSD;
      end
    end
  end

  // next stream state
  always_comb begin
    hist_d  = hist_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    if (s_acc) begin
      if (s_axis_tlast) begin
        hist_d  = '0;
        pos_d   = '0;
        flags_d = '0;
      end else begin
        if (active) begin
          hist_d = hist_new;
        end
        pos_d   = pos_upd;
        flags_d = flags_upd;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_short_d = out_short_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (s_acc && s_axis_tlast) begin
      out_valid_d = 1'b1;
      out_short_d = (pos_upd < hswm_pkg::pos_t'(hswm_pkg::HEADER_BYTES));
      out_code_d  = out_short_d ? hswm_pkg::CODE_NONE : code_sel;
    end
  end

  // control and stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_set_q <= hswm_pkg::CHECK_VOLUME;
      hist_q      <= '0;
      pos_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        check_set_q <= cfg_data_i;
      end
      hist_q      <= hist_d;
      pos_q       <= pos_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_code_q  <= out_code_d;
    out_short_q <= out_short_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_short_q, out_code_q};

  // assertions
  `HSWM_ASSERT(a_pos_bound, pos_q <= hswm_pkg::pos_t'(hswm_pkg::HEADER_BYTES), "byte counter past header length")
  `HSWM_ASSERT(a_short_none, (out_valid_q && out_short_q) |-> (out_code_q == hswm_pkg::CODE_NONE), "short header with a found code")
  `HSWM_ASSERT(a_clear_after_last, (s_acc && s_axis_tlast) |=> (pos_q == '0 && flags_q == '0 && out_valid_q), "stream state not cleared after last byte")
  `HSWM_ASSERT(a_flags_need_bytes, (flags_q != '0) |-> (pos_q != '0), "match flag set with no bytes counted")

endmodule

[design/hswm_sig_match.sv]
// signature compare against the updated byte history, with start window checks
`timescale 1ns / 1ps

module hswm_sig_match (
  input  hswm_pkg::hist_t      hist_i,   // history including the new byte, entry 0 newest
  input  hswm_pkg::pos_t       pos_i,    // offset of the new byte
  input  logic                 active_i, // new byte lies inside the header
  output hswm_pkg::sig_flags_t hit_o
);

  // one compare per signature; the signature ends at the new byte, so its
  // start lies in [lo, hi] exactly when pos is in [lo + len - 1, hi + len - 1]
  always_comb begin
    logic eq;
    logic win;
    for (int i = 0; i < hswm_pkg::SIG_COUNT; i++) begin
      eq = 1'b1;
      for (int j = 0; j < hswm_pkg::HIST_LEN; j++) begin
        if (j < hswm_pkg::SIG_LEN[i]) begin
          eq = eq & (hist_i[j] == hswm_pkg::SIG_BYTES[i][hswm_pkg::SIG_LEN[i] - 1 - j]);
        end
      end
      win = (pos_i >= hswm_pkg::pos_t'(hswm_pkg::SIG_LO[i] + hswm_pkg::SIG_LEN[i] - 1)) &&
            (pos_i <= hswm_pkg::pos_t'(hswm_pkg::SIG_HI[i] + hswm_pkg::SIG_LEN[i] - 1));
      hit_o[i] = active_i & win & eq;
    end
  end

endmodule
